@@ sv/aes_iks_pkg.sv @@
// Shared types and constants for the AES-128 inverse key schedule.
// Holds the forward S-box, the round constants and the key word types.
// No dependencies.
package aes_iks_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    // One AES-128 round key as four words; w0 carries key byte 0 in bits 31:24.
    typedef struct packed {
        word_t w3;
        word_t w2;
        word_t w1;
        word_t w0;
    } key_t;

    localparam int NumRounds = 10;

    localparam byte_t SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Rcon for rounds 1..10, indexed from 0.
    localparam byte_t RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

endpackage

@@ sv/aes_iks_round.sv @@
// One backward step of the AES-128 key expansion: round key r to round key r-1.
// Pure combinational; uses aes_iks_pkg for the S-box and key types.
module aes_iks_round (
    input  aes_iks_pkg::key_t  key_in,   // round r key
    input  aes_iks_pkg::byte_t rcon,     // Rcon for round r
    output aes_iks_pkg::key_t  key_out   // round r-1 key
);

    aes_iks_pkg::word_t prev3;
    aes_iks_pkg::word_t rot;
    aes_iks_pkg::word_t sub;

    assign prev3 = key_in.w3 ^ key_in.w2;

    // RotWord then SubWord on the recovered last word
    assign rot = {prev3[23:0], prev3[31:24]};
    assign sub = {aes_iks_pkg::SBOX[rot[31:24]], aes_iks_pkg::SBOX[rot[23:16]],
                  aes_iks_pkg::SBOX[rot[15:8]],  aes_iks_pkg::SBOX[rot[7:0]]};

    assign key_out.w3 = prev3;
    assign key_out.w2 = key_in.w2 ^ key_in.w1;
    assign key_out.w1 = key_in.w1 ^ key_in.w0;
    assign key_out.w0 = key_in.w0 ^ sub ^ {rcon, 24'h000000};

endmodule

@@ sv/aes128_inverse_key_schedule.sv @@
// AES-128 inverse key schedule: round 10 key in, cipher key out.
// Path from input transaction to result valid: input register, then result register.
// Throughput: one key per cycle while m_tready does not stall the result register; the ten
// backward rounds sit as one combinational chain of aes_iks_round between the two registers.
// Reset: aresetn synchronous, active low; clears both valid flags, data is not reset.
module aes128_inverse_key_schedule (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // round_key_word0, round_key_word1, round_key_word2,
                                    // round_key_word3 (32 bits each, lowest first)

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // cipher_key_word0, cipher_key_word1, cipher_key_word2,
                                    // cipher_key_word3 (32 bits each, lowest first)
);

    // ---------------------------------------------------------------
    // Stage 1: input register
    // ---------------------------------------------------------------
    logic               in_valid_reg;
    aes_iks_pkg::key_t  in_key_reg;
    logic               out_ready;   // result register can take a transaction
    logic               advance;     // stage 1 moves into the result register

    assign out_ready = !m_tvalid || m_tready;
    assign advance   = in_valid_reg && out_ready;
    // Input stage frees up whenever its contents move on, so a full pipe still
    // takes a new transaction in the cycle the result is taken.
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_key_reg.w0 <= s_tdata[31:0];
            in_key_reg.w1 <= s_tdata[63:32];
            in_key_reg.w2 <= s_tdata[95:64];
            in_key_reg.w3 <= s_tdata[127:96];
        end
    end

    // ---------------------------------------------------------------
    // Backward expansion: round 10 key down to round 0 key
    // ---------------------------------------------------------------
    aes_iks_pkg::key_t round_key [aes_iks_pkg::NumRounds+1];

    assign round_key[aes_iks_pkg::NumRounds] = in_key_reg;

    for (genvar r = aes_iks_pkg::NumRounds; r >= 1; r--) begin : g_round
        aes_iks_round u_round (
            .key_in  (round_key[r]),
            .rcon    (aes_iks_pkg::RCON[r-1]),
            .key_out (round_key[r-1])
        );
    end

    // ---------------------------------------------------------------
    // Stage 2: result register
    // ---------------------------------------------------------------
    logic               out_valid_reg;
    logic               out_valid_next;
    aes_iks_pkg::key_t  out_key_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_key_reg <= round_key[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_key_reg.w3, out_key_reg.w2, out_key_reg.w1, out_key_reg.w0};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted transaction lost in input stage");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("transaction lost between stages");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg && $stable(in_key_reg))
        else $error("stalled input stage overwritten");

endmodule
